>>> design/sirt_pkg.sv
// Shared types, constants and helpers for the signed integer to radix text block.
package sirt_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int LEN_W       = 5;
    localparam int DIGIT_W     = 4;
    localparam int NUM_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int ALPHA_W     = 2 * CFG_DATA_W;
    localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(NUM_W);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_HIGH = 2'd2;

    localparam logic [LEN_W-1:0]      BASE_LENGTH_RST = 5'd10;
    localparam logic [CFG_DATA_W-1:0] DIGITS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] DIGITS_HIGH_RST = 64'h0000000000003938;

    typedef logic [ALPHA_W-1:0] alpha_t;

    // One queued job: sign and magnitude of a number that passed the alphabet check.
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [CHAR_W-1:0] alpha_at(input alpha_t alpha,
                                                   input logic [DIGIT_W-1:0] pos);
        return alpha[pos * CHAR_W +: CHAR_W];
    endfunction

endpackage

>>> design/sirt_front.sv
// Front end: accepts numbers, checks the digit alphabet and queues valid jobs.
module sirt_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sirt_pkg::NUM_W-1:0] s_number,
    input  logic [sirt_pkg::LEN_W-1:0]        base_len,
    input  sirt_pkg::alpha_t                  alpha,
    input  sirt_pkg::q_status_t               q_status,
    output logic                              q_push,
    output sirt_pkg::item_t                   q_item
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_PUSH  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [sirt_pkg::DIGIT_W-1:0]     idx_reg, idx_next;
    sirt_pkg::item_t                  item_reg, item_next;
    logic                             accept;
    logic                             len_ok;
    logic                             bad;
    logic [sirt_pkg::CHAR_W-1:0]      cur_char;
    logic [sirt_pkg::LEN_W-1:0]       idx_ext;
    logic [sirt_pkg::NUM_W-1:0]       raw;

    assign s_ready  = (state_reg == F_IDLE);
    assign accept   = s_valid && s_ready;
    assign len_ok   = (base_len >= sirt_pkg::LEN_W'(2)) &&
                      (base_len <= sirt_pkg::LEN_W'(sirt_pkg::MAX_RADIX));
    assign raw      = s_number;
    assign cur_char = sirt_pkg::alpha_at(alpha, idx_reg);
    assign idx_ext  = {1'b0, idx_reg};
    assign q_push   = (state_reg == F_PUSH) && !q_status.full;
    assign q_item   = item_reg;

    // One alphabet position per cycle is compared against every later position.
    always_comb begin
        bad = (cur_char == sirt_pkg::CHAR_PLUS) || (cur_char == sirt_pkg::CHAR_MINUS);
        for (int j = 0; j < sirt_pkg::MAX_RADIX; j++) begin
            if ((sirt_pkg::LEN_W'(j) > idx_ext) && (sirt_pkg::LEN_W'(j) < base_len) &&
                (sirt_pkg::alpha_at(alpha, sirt_pkg::DIGIT_W'(j)) == cur_char)) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        item_next  = item_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    item_next.neg = raw[sirt_pkg::NUM_W-1];
                    item_next.mag = raw[sirt_pkg::NUM_W-1] ? (~raw + 1'b1) : raw;
                    idx_next      = '0;
                    // An unusable length drops the word at once.
                    state_next    = len_ok ? F_CHECK : F_IDLE;
                end
            end
            F_CHECK: begin
                if (bad) begin
                    state_next = F_IDLE;
                end else if (idx_ext == base_len - 1'b1) begin
                    state_next = F_PUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            F_PUSH: begin
                if (!q_status.full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg  <= idx_next;
        item_reg <= item_next;
    end

endmodule

>>> design/sirt_fifo.sv
// Two-entry queue of checked jobs between the front and back ends.
module sirt_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sirt_pkg::item_t     push_item,
    input  logic                pop,
    output sirt_pkg::item_t     pop_item,
    output sirt_pkg::q_status_t status
);

    logic [1:0]      count_reg, count_next;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    sirt_pkg::item_t entry_reg [2];
    logic            do_push;
    logic            do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("job pushed into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count out of range");

endmodule

>>> design/sirt_back.sv
// Back end: bit-serial division into digits, then emission of the text bytes.
module sirt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sirt_pkg::q_status_t           q_status,
    input  sirt_pkg::item_t               q_item,
    output logic                          q_pop,
    input  logic [sirt_pkg::LEN_W-1:0]    base_len,
    input  sirt_pkg::alpha_t              alpha,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sirt_pkg::CHAR_W-1:0]   m_character,
    output logic                          m_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_SIGN = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic                               neg_reg, neg_next;
    logic [sirt_pkg::NUM_W-1:0]         mag_reg, mag_next;
    logic [sirt_pkg::DIGIT_W-1:0]       rem_reg, rem_next;
    logic [sirt_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [sirt_pkg::NDIG_W-1:0]        nd_reg, nd_next;
    logic                               m_valid_reg, m_valid_next;
    logic [sirt_pkg::CHAR_W-1:0]        m_char_reg, m_char_next;
    logic                               m_last_reg, m_last_next;
    logic [sirt_pkg::DIGIT_W-1:0]       digit_buf_reg [sirt_pkg::MAX_DIGITS];

    logic                               slot_free;
    logic [sirt_pkg::LEN_W-1:0]         trial;
    logic [sirt_pkg::LEN_W-1:0]         diff;
    logic                               ge;
    logic [sirt_pkg::DIGIT_W-1:0]       rem_new;
    logic [sirt_pkg::NUM_W-1:0]         mag_shift;
    logic [sirt_pkg::NDIG_W-1:0]        nd_inc;
    logic [sirt_pkg::NDIG_W-1:0]        nd_dec;
    logic                               digit_done;
    logic                               buf_we;

    assign slot_free   = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;
    assign q_pop       = (state_reg == B_IDLE) && !q_status.empty;

    // Restoring division step: bring down the next dividend bit, subtract if it fits.
    assign trial     = {rem_reg, mag_reg[sirt_pkg::NUM_W-1]};
    assign ge        = (trial >= base_len);
    assign diff      = trial - base_len;
    assign rem_new   = ge ? diff[sirt_pkg::DIGIT_W-1:0] : trial[sirt_pkg::DIGIT_W-1:0];
    assign mag_shift = {mag_reg[sirt_pkg::NUM_W-2:0], ge};
    assign nd_inc    = nd_reg + 1'b1;
    assign nd_dec    = nd_reg - 1'b1;
    assign digit_done = (state_reg == B_DIV) &&
                        (bit_cnt_reg == sirt_pkg::BIT_CNT_W'(sirt_pkg::NUM_W - 1));
    assign buf_we    = digit_done;

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        nd_next      = nd_reg;
        m_valid_next = slot_free ? 1'b0 : m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    neg_next     = q_item.neg;
                    mag_next     = q_item.mag;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    nd_next      = '0;
                    state_next   = B_DIV;
                end
            end
            B_DIV: begin
                mag_next     = mag_shift;
                rem_next     = rem_new;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (digit_done) begin
                    rem_next = '0;
                    nd_next  = nd_inc;
                    if ((mag_shift == '0) ||
                        (nd_inc == sirt_pkg::NDIG_W'(sirt_pkg::MAX_DIGITS))) begin
                        state_next = neg_reg ? B_SIGN : B_EMIT;
                    end
                end
            end
            B_SIGN: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = sirt_pkg::CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = B_EMIT;
                end
            end
            B_EMIT: begin
                // Digits come out of the buffer in reverse order of their generation.
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = sirt_pkg::alpha_at(alpha,
                                       digit_buf_reg[nd_dec[sirt_pkg::NDIG_W-2:0]]);
                    m_last_next  = (nd_reg == sirt_pkg::NDIG_W'(1));
                    nd_next      = nd_dec;
                    if (nd_reg == sirt_pkg::NDIG_W'(1)) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            nd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nd_reg      <= nd_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        if (buf_we) begin
            digit_buf_reg[nd_reg[sirt_pkg::NDIG_W-2:0]] <= rem_new;
        end
    end

    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> ({1'b0, rem_reg} < base_len))
        else $error("division remainder not below the radix");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        nd_reg <= sirt_pkg::NDIG_W'(sirt_pkg::MAX_DIGITS))
        else $error("digit count exceeds its limit");

    a_emit_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT) |-> (nd_reg != '0))
        else $error("emitting with no digit left");

endmodule

>>> design/signed_int_to_radix_text.sv
// Top level of the signed integer to radix text converter.
// Usage: a 32-bit signed word on s_number (valid/ready) is printed as text on
// m_character/m_last (valid/ready), one byte per word: an optional '-' and then
// the magnitude's digits, most significant first, with m_last on the final byte.
// The radix is base_length and the digits come from digits_low/digits_high,
// written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// Each number is first checked against the alphabet, one position per cycle; a
// bad alphabet drops the number silently. Checked numbers wait in a two-entry
// queue for the back end, which divides by the radix bit-serially, one digit
// per pass over all 32 bits of the magnitude. The back end takes the next
// queued number only after it has issued the final byte of the current one.
// A stalled receiver holds the output register, and the back end waits on it;
// the front end keeps accepting and checking until a checked number finds the
// queue full.
// Reset is synchronous and active low; it empties the queue, drops any output
// and restores radix ten with the digits 0 to 9.
module signed_int_to_radix_text (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [sirt_pkg::NUM_W-1:0]       s_number,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [sirt_pkg::CHAR_W-1:0]             m_character,
    output logic                                    m_last,
    input  logic                                    cfg_we,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    logic [sirt_pkg::LEN_W-1:0]      base_len_reg;
    logic [sirt_pkg::CFG_DATA_W-1:0] digits_low_reg;
    logic [sirt_pkg::CFG_DATA_W-1:0] digits_high_reg;
    sirt_pkg::alpha_t                alpha;
    sirt_pkg::q_status_t             q_status;
    sirt_pkg::item_t                 push_item;
    sirt_pkg::item_t                 pop_item;
    logic                            q_push;
    logic                            q_pop;

    assign alpha = {digits_high_reg, digits_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg    <= sirt_pkg::BASE_LENGTH_RST;
            digits_low_reg  <= sirt_pkg::DIGITS_LOW_RST;
            digits_high_reg <= sirt_pkg::DIGITS_HIGH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sirt_pkg::REG_BASE_LENGTH: base_len_reg    <= cfg_wdata[sirt_pkg::LEN_W-1:0];
                sirt_pkg::REG_DIGITS_LOW:  digits_low_reg  <= cfg_wdata;
                sirt_pkg::REG_DIGITS_HIGH: digits_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sirt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_number (s_number),
        .base_len (base_len_reg),
        .alpha    (alpha),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sirt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    sirt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .base_len    (base_len_reg),
        .alpha       (alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

>>> sim/tb_top.sv
// Testbench for the signed integer to radix text converter, checked against a built-in predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sirt_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 20000;

    typedef struct packed {
        logic [sirt_pkg::CHAR_W-1:0] character;
        logic                        last;
    } text_byte_t;

    typedef enum {FAULT_NONE, FAULT_SHORT, FAULT_SIGN, FAULT_REPEAT, FAULT_OVERSIZE} alpha_fault_t;
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic signed [sirt_pkg::NUM_W-1:0]  s_number  = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [sirt_pkg::CHAR_W-1:0]        m_character;
    logic                               m_last;
    logic                               cfg_we    = 1'b0;
    logic [sirt_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [sirt_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

    // Predictor's copy of the configuration registers.
    logic [sirt_pkg::LEN_W-1:0]      radix_cfg     = sirt_pkg::BASE_LENGTH_RST;
    logic [sirt_pkg::CFG_DATA_W-1:0] digits_lo_cfg = sirt_pkg::DIGITS_LOW_RST;
    logic [sirt_pkg::CFG_DATA_W-1:0] digits_hi_cfg = sirt_pkg::DIGITS_HIGH_RST;

    text_byte_t expected_text[$];
    text_byte_t want;
    int         error_count  = 0;
    int         stall_cycles = 0;
    int         burst_left   = 0;
    bit         hold_request = 1'b0;

    signed_int_to_radix_text i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_number    (s_number),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [sirt_pkg::CHAR_W-1:0] digit_char(input int pos);
        return (pos < 8) ? digits_lo_cfg[pos*8 +: 8] : digits_hi_cfg[(pos-8)*8 +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int len;
        len = radix_cfg;
        if (len < 2 || len > sirt_pkg::MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (digit_char(i) == sirt_pkg::CHAR_PLUS || digit_char(i) == sirt_pkg::CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < len; j++)
                if (digit_char(j) == digit_char(i))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the characters that one accepted number must produce.
    function automatic void predict_text(input logic signed [sirt_pkg::NUM_W-1:0] number);
        logic [sirt_pkg::NUM_W-1:0]  mag;
        logic [sirt_pkg::NUM_W-1:0]  radix;
        logic [sirt_pkg::CHAR_W-1:0] digit_bytes[$];
        if (!alphabet_valid())
            return;
        radix = sirt_pkg::NUM_W'(radix_cfg);
        mag = number[sirt_pkg::NUM_W-1] ? ~number + 1'b1 : number;
        do begin
            digit_bytes.push_front(digit_char(int'(mag % radix)));
            mag = mag / radix;
        end while (mag != 0);
        if (number[sirt_pkg::NUM_W-1])
            expected_text.push_back('{character: sirt_pkg::CHAR_MINUS, last: 1'b0});
        foreach (digit_bytes[i])
            expected_text.push_back('{character: digit_bytes[i],
                                      last: (i == digit_bytes.size() - 1)});
    endfunction

    function automatic sirt_pkg::alpha_t alphabet_from_string(input string text);
        sirt_pkg::alpha_t a;
        a = '0;
        for (int i = 0; i < text.len() && i < sirt_pkg::MAX_RADIX; i++)
            a[i*8 +: 8] = text[i];
        return a;
    endfunction

    function automatic logic signed [sirt_pkg::NUM_W-1:0] random_number();
        logic [sirt_pkg::NUM_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 255);
            5, 6, 7: v = $urandom_range(0, 65535);
            8: v = $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Builds a random alphabet, then breaks it in the way the fault asks for.
    task automatic pick_alphabet(input alpha_fault_t fault,
                                 output logic [sirt_pkg::LEN_W-1:0] len,
                                 output sirt_pkg::alpha_t chars);
        bit                          used[256];
        int                          n;
        int                          zero_pos;
        int                          a;
        int                          b;
        logic [sirt_pkg::CHAR_W-1:0] c;
        n = $urandom_range(2, sirt_pkg::MAX_RADIX);
        zero_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        foreach (used[i])
            used[i] = 1'b0;
        if (zero_pos >= 0)
            used[0] = 1'b1;
        for (int i = 0; i < sirt_pkg::MAX_RADIX; i++) begin
            if (i == zero_pos) begin
                c = 8'h00;
            end else if (i >= n) begin
                c = sirt_pkg::CHAR_W'($urandom_range(0, 255));
            end else begin
                do c = sirt_pkg::CHAR_W'($urandom_range(0, 255));
                while (c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS || used[c]);
                used[c] = 1'b1;
            end
            chars[i*8 +: 8] = c;
        end
        len = sirt_pkg::LEN_W'(n);
        case (fault)
            FAULT_SHORT: len = sirt_pkg::LEN_W'($urandom_range(0, 1));
            FAULT_SIGN: begin
                a = $urandom_range(0, n - 1);
                chars[a*8 +: 8] = $urandom_range(0, 1) ? sirt_pkg::CHAR_PLUS
                                                       : sirt_pkg::CHAR_MINUS;
            end
            FAULT_REPEAT: begin
                a = $urandom_range(0, n - 1);
                do b = $urandom_range(0, n - 1);
                while (b == a);
                chars[b*8 +: 8] = chars[a*8 +: 8];
            end
            FAULT_OVERSIZE: len = sirt_pkg::LEN_W'($urandom_range(sirt_pkg::MAX_RADIX + 1, 31));
            default: ;
        endcase
    endtask

    // Leaves cfg_we high so that back-to-back writes need no toggle.
    task automatic write_register(input logic [sirt_pkg::CFG_INDEX_W-1:0] reg_index,
                                  input logic [sirt_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_wdata <= data;
        @(posedge aclk);
        case (reg_index)
            sirt_pkg::REG_BASE_LENGTH: radix_cfg     = data[sirt_pkg::LEN_W-1:0];
            sirt_pkg::REG_DIGITS_LOW:  digits_lo_cfg = data;
            sirt_pkg::REG_DIGITS_HIGH: digits_hi_cfg = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk);
        while (expected_text.size() != 0);
        // A rejected number may still be in the alphabet check.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_alphabet(input logic [sirt_pkg::LEN_W-1:0] len,
                                 input sirt_pkg::alpha_t chars);
        logic [sirt_pkg::CFG_DATA_W-1:0] length_word;
        wait_idle();
        length_word = {$urandom, $urandom};
        length_word[sirt_pkg::LEN_W-1:0] = len;
        write_register(sirt_pkg::REG_BASE_LENGTH, length_word);
        write_register(sirt_pkg::REG_DIGITS_LOW, chars[sirt_pkg::CFG_DATA_W-1:0]);
        write_register(sirt_pkg::REG_DIGITS_HIGH,
                       chars[sirt_pkg::ALPHA_W-1:sirt_pkg::CFG_DATA_W]);
        cfg_we <= 1'b0;
    endtask

    // Offers one number in the current burst, or opens a new burst after a gap.
    task automatic send_number(input logic signed [sirt_pkg::NUM_W-1:0] number);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1, 2: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 40);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_number <= number;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_text(number);
    endtask

    task automatic test_reset_decimal();
        send_number(0);
        send_number(1);
        send_number(-1);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(-123456789);
    endtask

    task automatic test_binary_extremes();
        load_alphabet(2, alphabet_from_string("01"));
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(-1);
    endtask

    task automatic test_hex_extremes();
        load_alphabet(16, alphabet_from_string("0123456789ABCDEF"));
        send_number(0);
        send_number(32'sh89AB_CDEF);
        send_number(255);
        send_number(32'sh7FFF_FFFF);
    endtask

    task automatic test_zero_byte_digits();
        sirt_pkg::alpha_t chars;
        chars = '0;
        chars[15:8]  = 8'hFF;
        chars[23:16] = "z";
        load_alphabet(3, chars);
        send_number(0);
        send_number(-7);
        send_number(80);
        // A minus sign just past the alphabet's end is not part of it.
        load_alphabet(2, alphabet_from_string("xy-"));
        send_number(6);
    endtask

    task automatic test_bad_alphabets();
        load_alphabet(1, alphabet_from_string("01"));
        send_number(5);
        load_alphabet(0, alphabet_from_string("01"));
        send_number(-5);
        load_alphabet(3, alphabet_from_string("0+2"));
        send_number(7);
        load_alphabet(3, alphabet_from_string("ab-"));
        send_number(-7);
        load_alphabet(4, alphabet_from_string("abca"));
        send_number(100);
        load_alphabet(17, alphabet_from_string("0123456789ABCDEF"));
        send_number(100);
        load_alphabet(31, alphabet_from_string("0123456789ABCDEF"));
        send_number(-100);
    endtask

    task automatic test_unknown_register();
        load_alphabet(10, alphabet_from_string("0123456789"));
        send_number(42);
        wait_idle();
        write_register(REG_SPARE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_number(-42);
    endtask

    // The receiver holds off while numbers keep coming, then the sender waits for the drain.
    task automatic test_backpressure();
        load_alphabet(10, alphabet_from_string("0123456789"));
        hold_request = 1'b1;
        repeat (10) send_number($urandom);
        wait_idle();
    endtask

    task automatic test_random_radix();
        int                         counted;
        int                         n;
        logic [sirt_pkg::LEN_W-1:0] len;
        sirt_pkg::alpha_t           chars;
        alpha_fault_t               fault;
        counted = 0;
        while (counted < 250) begin
            fault = ($urandom_range(0, 4) == 0) ? alpha_fault_t'($urandom_range(1, 4))
                                                : FAULT_NONE;
            pick_alphabet(fault, len, chars);
            load_alphabet(len, chars);
            n = (fault == FAULT_NONE) ? $urandom_range(10, 40) : $urandom_range(2, 6);
            repeat (n) begin
                send_number(random_number());
                if (fault == FAULT_NONE)
                    counted++;
            end
        end
    endtask

    // Receiver: ready follows a pattern that changes now and then.
    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode_left = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 1500);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (tick % 16 == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected word: character 8'h%02h, last %b", m_character, m_last);
                error_count++;
            end else begin
                want = expected_text.pop_front();
                if (m_character !== want.character) begin
                    $error("character: expected 8'h%02h, got 8'h%02h",
                           want.character, m_character);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no word moved for %0d cycles, %0d characters outstanding",
                       stall_cycles, expected_text.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_decimal();
        test_binary_extremes();
        test_hex_extremes();
        test_zero_byte_digits();
        test_bad_alphabets();
        test_unknown_register();
        test_backpressure();
        test_random_radix();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_text.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
